[hw/rtl/letterbox_bilinear_resize_defines.svh]
// Assertion macros for the letterbox resize block.
`ifndef LETTERBOX_BILINEAR_RESIZE_DEFINES_SVH
`define LETTERBOX_BILINEAR_RESIZE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbr check failed");

// Next-cycle implication, disabled in reset.
`define LBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbr check failed");

`endif

[hw/rtl/lbr_pkg.sv]
// Shared types and constants of the letterbox resize block.
package lbr_pkg;

    localparam int SRC_DIM_W = 11;
    localparam int DST_DIM_W = 12;
    localparam int COORD_W   = 12;
    localparam int INV_W     = 28;
    localparam int CHAN_W    = 8;
    localparam int CHANNELS  = 3;
    localparam int PIX_W     = CHAN_W * CHANNELS;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    localparam logic [OUT_W-1:0] PAD_VALUE = 16'd29184;   // gray 114 in Q8.8

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_H = 2'd3;

    typedef struct packed {
        logic                 busy;
        logic [INV_W-1:0]     inv;
        logic [DST_DIM_W-1:0] sc_w;
        logic [DST_DIM_W-1:0] sc_h;
        logic [DST_DIM_W-1:0] pad_l;
        logic [DST_DIM_W-1:0] pad_t;
        logic [SRC_DIM_W-1:0] sw;
        logic [SRC_DIM_W-1:0] sh;
    } t_geom;

endpackage

[hw/rtl/lbr_ifs.sv]
// Word channel interfaces: request/load words in, pixel words out.
interface lbr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [lbr_pkg::COORD_W-1:0]   coord_x;
    logic [lbr_pkg::COORD_W-1:0]   coord_y;
    logic [lbr_pkg::CHAN_W-1:0]    red;
    logic [lbr_pkg::CHAN_W-1:0]    green;
    logic [lbr_pkg::CHAN_W-1:0]    blue;
    modport source (output valid, kind, coord_x, coord_y, red, green, blue, input ready);
    modport sink   (input valid, kind, coord_x, coord_y, red, green, blue, output ready);
endinterface

interface lbr_out_if;
    logic                        valid;
    logic                        ready;
    logic [lbr_pkg::OUT_W-1:0]   out_red;
    logic [lbr_pkg::OUT_W-1:0]   out_green;
    logic [lbr_pkg::OUT_W-1:0]   out_blue;
    logic                        is_padding;
    logic                        range_error;
    modport source (output valid, out_red, out_green, out_blue, is_padding, range_error,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, is_padding, range_error,
                    output ready);
endinterface

[hw/rtl/lbr_geom.sv]
// Geometry unit: scale, scaled size and padding, by serial restoring division.
module lbr_geom #(
    parameter int MAX_SRC_WIDTH  = 1024,
    parameter int MAX_SRC_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [lbr_pkg::SRC_DIM_W-1:0]       i_src_w,
    input  logic [lbr_pkg::SRC_DIM_W-1:0]       i_src_h,
    input  logic [lbr_pkg::DST_DIM_W-1:0]       i_dst_w,
    input  logic [lbr_pkg::DST_DIM_W-1:0]       i_dst_h,
    output lbr_pkg::t_geom                      o_geom
);
    localparam int SW = lbr_pkg::SRC_DIM_W;
    localparam int DW = lbr_pkg::DST_DIM_W;
    localparam int PW = SW + DW;          // dimension products
    localparam int QW = SW + 16;          // dividend / quotient width

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_CMP   = 6'b000100,
        ST_SETUP = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } t_gstate;

    t_gstate r_state, n_state;
    logic [SW-1:0] r_sw, r_sh, r_db, r_rb;
    logic [DW-1:0] r_dw, r_dh, r_da, r_ra;
    logic [PW-1:0] r_p1, r_p2;
    logic          r_gov;
    logic [QW-1:0] r_qa, r_qb;
    logic [4:0]    r_cnt;
    logic [lbr_pkg::INV_W-1:0] r_inv;
    logic [DW-1:0] r_scw, r_sch, r_padl, r_padt;

    logic [DW:0]   ta, na;
    logic          ga;
    logic [SW:0]   tb, nb;
    logic          gb;
    logic [DW-1:0] fin_w, fin_h;

    function automatic logic [SW-1:0] eff_src(input logic [SW-1:0] v, input int maxv);
        logic [SW-1:0] r;
        if (v == '0)
            r = SW'(1);
        else if ({2'b00, v} > (SW+2)'(maxv))
            r = SW'(maxv);
        else
            r = v;
        return r;
    endfunction

    always_comb begin
        ta = {r_ra, r_qa[QW-1]};
        ga = ta >= {1'b0, r_da};
        na = ga ? ta - {1'b0, r_da} : ta;
        tb = {r_rb, r_qb[QW-1]};
        gb = tb >= {1'b0, r_db};
        nb = gb ? tb - {1'b0, r_db} : tb;
        fin_w = r_gov ? r_dw : r_qb[DW-1:0];
        fin_h = r_gov ? r_qb[DW-1:0] : r_dh;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  n_state = ST_IDLE;
            ST_PREP:  n_state = ST_CMP;
            ST_CMP:   n_state = ST_SETUP;
            ST_SETUP: n_state = ST_DIV;
            ST_DIV:   n_state = (r_cnt == 5'(QW-1)) ? ST_FIN : ST_DIV;
            ST_FIN:   n_state = ST_IDLE;
            default:  n_state = ST_PREP;
        endcase
        if (i_start)
            n_state = ST_PREP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PREP;
            r_inv   <= '0;
            r_scw   <= '0;
            r_sch   <= '0;
            r_padl  <= '0;
            r_padt  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FIN) begin
                r_inv  <= lbr_pkg::INV_W'(r_qa);
                r_scw  <= fin_w;
                r_sch  <= fin_h;
                r_padl <= (r_dw - fin_w) >> 1;
                r_padt <= (r_dh - fin_h) >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_PREP: begin
                r_sw <= eff_src(i_src_w, MAX_SRC_WIDTH);
                r_sh <= eff_src(i_src_h, MAX_SRC_HEIGHT);
                r_dw <= (i_dst_w == '0) ? DW'(1) : i_dst_w;
                r_dh <= (i_dst_h == '0) ? DW'(1) : i_dst_h;
            end
            ST_CMP: begin
                r_p1 <= PW'(r_dw * r_sh);
                r_p2 <= PW'(r_dh * r_sw);
            end
            ST_SETUP: begin
                r_gov <= r_p1 <= r_p2;
                r_qa  <= (r_p1 <= r_p2) ? {r_sw, 16'h0} : {r_sh, 16'h0};
                r_da  <= (r_p1 <= r_p2) ? r_dw : r_dh;
                r_qb  <= (r_p1 <= r_p2) ? QW'(r_p1) : QW'(r_p2);
                r_db  <= (r_p1 <= r_p2) ? r_sw : r_sh;
                r_ra  <= '0;
                r_rb  <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_ra  <= na[DW-1:0];
                r_qa  <= {r_qa[QW-2:0], ga};
                r_rb  <= nb[SW-1:0];
                r_qb  <= {r_qb[QW-2:0], gb};
                r_cnt <= r_cnt + 5'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_geom.busy  = r_state != ST_IDLE;
    assign o_geom.inv   = r_inv;
    assign o_geom.sc_w  = r_scw;
    assign o_geom.sc_h  = r_sch;
    assign o_geom.pad_l = r_padl;
    assign o_geom.pad_t = r_padt;
    assign o_geom.sw    = r_sw;
    assign o_geom.sh    = r_sh;

endmodule

[hw/rtl/lbr_frame.sv]
// Source frame store: four banks split by row and column parity.
module lbr_frame #(
    parameter int MAX_SRC_WIDTH  = 1024,
    parameter int MAX_SRC_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic                              i_we,
    input  logic [$clog2(MAX_SRC_WIDTH)-1:0]  i_wx,
    input  logic [$clog2(MAX_SRC_HEIGHT)-1:0] i_wy,
    input  logic [lbr_pkg::PIX_W-1:0]         i_wdata,
    input  logic [$clog2(MAX_SRC_WIDTH)-1:0]  i_x0,
    input  logic [$clog2(MAX_SRC_WIDTH)-1:0]  i_x1,
    input  logic [$clog2(MAX_SRC_HEIGHT)-1:0] i_y0,
    input  logic [$clog2(MAX_SRC_HEIGHT)-1:0] i_y1,
    output logic [lbr_pkg::PIX_W-1:0]         o_p00,
    output logic [lbr_pkg::PIX_W-1:0]         o_p01,
    output logic [lbr_pkg::PIX_W-1:0]         o_p10,
    output logic [lbr_pkg::PIX_W-1:0]         o_p11
);
    localparam int XW    = $clog2(MAX_SRC_WIDTH);
    localparam int YW    = $clog2(MAX_SRC_HEIGHT);
    localparam int HW    = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HH    = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int DEPTH = HW * HH;
    localparam int AW    = $clog2(DEPTH);

    logic [lbr_pkg::PIX_W-1:0] r_rd [4];
    logic [AW-1:0]             waddr;
    logic [1:0]                wbank;
    logic                      r_x0p, r_y0p, r_xsame, r_ysame;

    assign wbank = {i_wy[0], i_wx[0]};
    assign waddr = AW'(i_wy[YW-1:1]) * AW'(HW) + AW'(i_wx[XW-1:1]);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'(b / 2);
        logic [lbr_pkg::PIX_W-1:0] r_mem [DEPTH];
        logic [XW-2:0] rcol;
        logic [YW-2:0] rrow;
        logic [AW-1:0] raddr;

        assign rcol  = (i_x0[0] == PX) ? i_x0[XW-1:1] : i_x1[XW-1:1];
        assign rrow  = (i_y0[0] == PY) ? i_y0[YW-1:1] : i_y1[YW-1:1];
        assign raddr = AW'(rrow) * AW'(HW) + AW'(rcol);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_we && wbank == 2'(b))
                    r_mem[waddr] <= i_wdata;
                r_rd[b] <= r_mem[raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0p   <= i_x0[0];
            r_y0p   <= i_y0[0];
            r_xsame <= i_x0 == i_x1;
            r_ysame <= i_y0 == i_y1;
        end
    end

    // clamped neighbors share the bank of the base pixel
    logic x1p, y1p;
    assign x1p = r_xsame ? r_x0p : ~r_x0p;
    assign y1p = r_ysame ? r_y0p : ~r_y0p;

    assign o_p00 = r_rd[{r_y0p, r_x0p}];
    assign o_p01 = r_rd[{r_y0p, x1p}];
    assign o_p10 = r_rd[{y1p, r_x0p}];
    assign o_p11 = r_rd[{y1p, x1p}];

endmodule

[hw/rtl/letterbox_bilinear_resize.sv]
// Path: a request word passes stages 1 to 5, then the output register; loads give no word.
// Throughput: one word per cycle unless stalled, set by the read of the 4-bank frame store.
// The whole pipeline stalls while the output register holds an untaken word.
// After reset and after each config write the geometry divider runs through prepare,
// compare, setup, 27 quotient steps and finish; no word is accepted meanwhile.
// Reset clears pipeline valids and geometry; the frame store is not cleared.
`include "letterbox_bilinear_resize_defines.svh"

module letterbox_bilinear_resize #(
    parameter int MAX_SRC_WIDTH  = 1024,
    parameter int MAX_SRC_HEIGHT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lbr_in_if.sink                           i_in,
    lbr_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [lbr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lbr_pkg::CFG_DAT_W-1:0]    i_cfg_data
);
    localparam int XW  = $clog2(MAX_SRC_WIDTH);
    localparam int YW  = $clog2(MAX_SRC_HEIGHT);
    localparam int CW  = lbr_pkg::COORD_W;
    localparam int SW  = lbr_pkg::SRC_DIM_W;
    localparam int PXW = lbr_pkg::PIX_W;
    localparam int SXW = CW + lbr_pkg::INV_W;   // Q16 source position
    localparam int WW  = 17;                    // bilinear weight, up to 65536
    localparam int PRW = lbr_pkg::CHAN_W + WW;

    // ---- config registers
    logic [SW-1:0] r_src_w, r_src_h;
    logic [lbr_pkg::DST_DIM_W-1:0] r_dst_w, r_dst_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 11'd640;
            r_src_h <= 11'd640;
            r_dst_w <= 12'd640;
            r_dst_h <= 12'd640;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lbr_pkg::CFG_SRC_W: r_src_w <= i_cfg_data[SW-1:0];
                lbr_pkg::CFG_SRC_H: r_src_h <= i_cfg_data[SW-1:0];
                lbr_pkg::CFG_DST_W: r_dst_w <= i_cfg_data;
                lbr_pkg::CFG_DST_H: r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lbr_pkg::t_geom geom;

    lbr_geom #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_src_w (r_src_w),
        .i_src_h (r_src_h),
        .i_dst_w (r_dst_w),
        .i_dst_h (r_dst_h),
        .o_geom  (geom)
    );

    // ---- pipeline control: every stage moves together with the output register
    logic en, accept;
    logic r_out_valid;
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en && !geom.busy;
    assign accept     = i_in.valid && i_in.ready;

    // stage 1: captured word
    logic          r1_valid, r1_kind;
    logic [CW-1:0] r1_x, r1_y;
    logic [PXW-1:0] r1_pix;
    // stage 2: classified
    logic          r2_valid, r2_kind, r2_ld_ok, r2_rerr, r2_pad;
    logic [CW-1:0] r2_u, r2_v, r2_x, r2_y;
    logic [PXW-1:0] r2_pix;
    // stage 3: source positions, store access
    logic          r3_valid, r3_kind, r3_ld_ok, r3_rerr, r3_pad;
    logic [SXW-1:0] r3_sx, r3_sy;
    logic [CW-1:0] r3_x, r3_y;
    logic [PXW-1:0] r3_pix;
    // stage 4: neighbor data and weights
    logic          r4_valid, r4_rerr, r4_pad;
    logic [WW-1:0] r4_w [4];
    // stage 5: weighted products per channel and neighbor
    logic          r5_valid, r5_rerr, r5_pad;
    logic [PRW-1:0] r5_prod [lbr_pkg::CHANNELS][4];

    // stage 1 classification
    logic          s1_rerr, s1_pad, s1_ld_ok;
    always_comb begin
        s1_rerr  = (r1_x >= r_dst_w) || (r1_y >= r_dst_h);
        s1_pad   = (r1_x < geom.pad_l) || ({1'b0, r1_x} >= {1'b0, geom.pad_l} + {1'b0, geom.sc_w})
                || (r1_y < geom.pad_t) || ({1'b0, r1_y} >= {1'b0, geom.pad_t} + {1'b0, geom.sc_h});
        s1_ld_ok = ({1'b0, r1_x} < (CW+1)'(MAX_SRC_WIDTH))
                && ({1'b0, r1_y} < (CW+1)'(MAX_SRC_HEIGHT));
    end

    // stage 3 neighbor indices and weights
    logic [SW-1:0] sw_m1, sh_m1, x0c, x1c, y0c, y1c;
    logic [lbr_pkg::CHAN_W-1:0] fx, fy;
    logic [8:0] wx0, wy0, wx1, wy1;
    always_comb begin
        sw_m1 = geom.sw - SW'(1);
        sh_m1 = geom.sh - SW'(1);
        x0c = (r3_sx[SXW-1:16] > (SXW-16)'(sw_m1)) ? sw_m1 : r3_sx[16 +: SW];
        y0c = (r3_sy[SXW-1:16] > (SXW-16)'(sh_m1)) ? sh_m1 : r3_sy[16 +: SW];
        x1c = ({1'b0, x0c} + 12'd1 < {1'b0, geom.sw}) ? x0c + SW'(1) : sw_m1;
        y1c = ({1'b0, y0c} + 12'd1 < {1'b0, geom.sh}) ? y0c + SW'(1) : sh_m1;
        fx  = r3_sx[15:8];
        fy  = r3_sy[15:8];
        wx1 = {1'b0, fx};
        wy1 = {1'b0, fy};
        wx0 = 9'd256 - wx1;
        wy0 = 9'd256 - wy1;
    end

    logic [PXW-1:0] p00, p01, p10, p11;

    lbr_frame #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)) u_frame (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (r3_valid && r3_kind == lbr_pkg::KIND_LOAD && r3_ld_ok),
        .i_wx    (r3_x[XW-1:0]),
        .i_wy    (r3_y[YW-1:0]),
        .i_wdata (r3_pix),
        .i_x0    (XW'(x0c)),
        .i_x1    (XW'(x1c)),
        .i_y0    (YW'(y0c)),
        .i_y1    (YW'(y1c)),
        .o_p00   (p00),
        .o_p01   (p01),
        .o_p10   (p10),
        .o_p11   (p11)
    );

    // stage 4 products, channel c sits at byte 2-c of the pixel word
    logic [PRW-1:0] s4_prod [lbr_pkg::CHANNELS][4];
    always_comb begin
        for (int c = 0; c < lbr_pkg::CHANNELS; c++) begin
            s4_prod[c][0] = PRW'(p00[PXW-1-8*c -: 8] * r4_w[0]);
            s4_prod[c][1] = PRW'(p01[PXW-1-8*c -: 8] * r4_w[1]);
            s4_prod[c][2] = PRW'(p10[PXW-1-8*c -: 8] * r4_w[2]);
            s4_prod[c][3] = PRW'(p11[PXW-1-8*c -: 8] * r4_w[3]);
        end
    end

    logic [PRW+1:0] s5_sum [lbr_pkg::CHANNELS];
    always_comb begin
        for (int c = 0; c < lbr_pkg::CHANNELS; c++)
            s5_sum[c] = (PRW+2)'(r5_prod[c][0]) + (PRW+2)'(r5_prod[c][1])
                      + (PRW+2)'(r5_prod[c][2]) + (PRW+2)'(r5_prod[c][3]);
    end

    // valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= accept;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid && r3_kind == lbr_pkg::KIND_REQ;
            r5_valid    <= r4_valid;
            r_out_valid <= r5_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind <= i_in.kind;
            r1_x    <= i_in.coord_x;
            r1_y    <= i_in.coord_y;
            r1_pix  <= {i_in.red, i_in.green, i_in.blue};

            r2_kind  <= r1_kind;
            r2_ld_ok <= s1_ld_ok;
            r2_rerr  <= s1_rerr;
            r2_pad   <= s1_pad;
            r2_u     <= r1_x - geom.pad_l;
            r2_v     <= r1_y - geom.pad_t;
            r2_x     <= r1_x;
            r2_y     <= r1_y;
            r2_pix   <= r1_pix;

            r3_kind  <= r2_kind;
            r3_ld_ok <= r2_ld_ok;
            r3_rerr  <= r2_rerr;
            r3_pad   <= r2_pad;
            r3_sx    <= SXW'(r2_u * geom.inv);
            r3_sy    <= SXW'(r2_v * geom.inv);
            r3_x     <= r2_x;
            r3_y     <= r2_y;
            r3_pix   <= r2_pix;

            r4_rerr <= r3_rerr;
            r4_pad  <= r3_pad;
            r4_w[0] <= WW'(wx0 * wy0);
            r4_w[1] <= WW'(wx1 * wy0);
            r4_w[2] <= WW'(wx0 * wy1);
            r4_w[3] <= WW'(wx1 * wy1);

            r5_rerr <= r4_rerr;
            r5_pad  <= r4_pad;
            r5_prod <= s4_prod;

            o_out.range_error <= r5_rerr;
            o_out.is_padding  <= r5_pad && !r5_rerr;
            if (r5_rerr) begin
                o_out.out_red   <= '0;
                o_out.out_green <= '0;
                o_out.out_blue  <= '0;
            end else if (r5_pad) begin
                o_out.out_red   <= lbr_pkg::PAD_VALUE;
                o_out.out_green <= lbr_pkg::PAD_VALUE;
                o_out.out_blue  <= lbr_pkg::PAD_VALUE;
            end else begin
                o_out.out_red   <= s5_sum[0][8 +: lbr_pkg::OUT_W];
                o_out.out_green <= s5_sum[1][8 +: lbr_pkg::OUT_W];
                o_out.out_blue  <= s5_sum[2][8 +: lbr_pkg::OUT_W];
            end
        end
    end

    assign o_out.valid = r_out_valid;

    `LBR_ASSERT_NOW(a_no_accept_busy, i_clk, i_rst_n, accept, !geom.busy)
    `LBR_ASSERT_NEXT(a_cfg_blocks_input, i_clk, i_rst_n, i_cfg_we, !i_in.ready)
    `LBR_ASSERT_NOW(a_flags_exclusive, i_clk, i_rst_n, o_out.valid,
                    !(o_out.is_padding && o_out.range_error))
    `LBR_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n,
                     r3_valid && r3_kind == lbr_pkg::KIND_LOAD && en, !r4_valid)

endmodule

[sim/testbench.sv]
// Testbench for the letterbox bilinear resize block: directed and random loads and requests, scoreboard check.
`timescale 1ns / 100ps

module testbench;

    localparam int STORE_W = 1024;
    localparam int STORE_H = 1024;
    localparam int DRAIN_CYCLES = 16;   // drains the pipe, plus margin
    localparam int PHASE_WORDS = 48;    // words per random phase, auto loads included

    typedef struct packed {
        logic                        kind;
        logic [lbr_pkg::COORD_W-1:0] x;
        logic [lbr_pkg::COORD_W-1:0] y;
        logic [lbr_pkg::CHAN_W-1:0]  r;
        logic [lbr_pkg::CHAN_W-1:0]  g;
        logic [lbr_pkg::CHAN_W-1:0]  b;
    } t_pixel_word;

    typedef struct packed {
        logic [lbr_pkg::OUT_W-1:0] r;
        logic [lbr_pkg::OUT_W-1:0] g;
        logic [lbr_pkg::OUT_W-1:0] b;
        logic                      pad;
        logic                      rerr;
    } t_result_word;

    // Scoreboard: its own copy of the registers, the frame store and the pending words.
    class t_pixel_scoreboard;
        int unsigned src_w = 640, src_h = 640, dst_w = 640, dst_h = 640;
        logic [lbr_pkg::PIX_W-1:0] frame[int];
        t_result_word pending_q[$];
        int mismatches, n_req, n_pad, n_rerr, n_load, n_checked;

        function void set_reg(logic [lbr_pkg::CFG_IDX_W-1:0] idx,
                              logic [lbr_pkg::CFG_DAT_W-1:0] d);
            case (idx)
                lbr_pkg::CFG_SRC_W: src_w = d[lbr_pkg::SRC_DIM_W-1:0];
                lbr_pkg::CFG_SRC_H: src_h = d[lbr_pkg::SRC_DIM_W-1:0];
                lbr_pkg::CFG_DST_W: dst_w = d;
                lbr_pkg::CFG_DST_H: dst_h = d;
                default: ;
            endcase
        endfunction

        function longint unsigned clamp_src(int unsigned v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function bit is_written(longint unsigned x, longint unsigned y);
            return frame.exists(int'(y * STORE_W + x));
        endfunction

        // Returns 1 when (x,y) is inside the scaled image; gives the neighbors and fractions.
        function bit sample_at(longint unsigned x, longint unsigned y,
                               output longint unsigned x0, x1, y0, y1, fx, fy);
            longint unsigned sw, sh, dw, dh, inv, scw, sch, pl, pt, sx, sy;
            sw = clamp_src(src_w, STORE_W);
            sh = clamp_src(src_h, STORE_H);
            dw = dst_w ? dst_w : 1;
            dh = dst_h ? dst_h : 1;
            if (dw * sh <= dh * sw) begin
                inv = ((sw << 16) / dw) & 28'hFFFFFFF;
                scw = dw;
                sch = (sh * dw) / sw;
            end else begin
                inv = ((sh << 16) / dh) & 28'hFFFFFFF;
                sch = dh;
                scw = (sw * dh) / sh;
            end
            pl = (dw - scw) / 2;
            pt = (dh - sch) / 2;
            x0 = 0; x1 = 0; y0 = 0; y1 = 0; fx = 0; fy = 0;
            if (x < pl || x >= pl + scw || y < pt || y >= pt + sch) return 0;
            sx = (x - pl) * inv;
            sy = (y - pt) * inv;
            x0 = sx >> 16;
            y0 = sy >> 16;
            if (x0 > sw - 1) x0 = sw - 1;
            if (y0 > sh - 1) y0 = sh - 1;
            x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
            y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
            fx = (sx >> 8) & 8'hFF;
            fy = (sy >> 8) & 8'hFF;
            return 1;
        endfunction

        function void note_word(t_pixel_word w);
            longint unsigned x0, x1, y0, y1, fx, fy, a, b, d, e, acc;
            logic [lbr_pkg::PIX_W-1:0] p00, p01, p10, p11;
            t_result_word res;
            int sh_bits;
            if (w.kind == lbr_pkg::KIND_LOAD) begin
                n_load++;
                if (w.x < STORE_W && w.y < STORE_H)
                    frame[int'(w.y) * STORE_W + int'(w.x)] = {w.r, w.g, w.b};
                return;
            end
            n_req++;
            res = '0;
            if (w.x >= dst_w || w.y >= dst_h) begin
                res.rerr = 1'b1;
                n_rerr++;
            end else if (!sample_at(w.x, w.y, x0, x1, y0, y1, fx, fy)) begin
                res.r = lbr_pkg::PAD_VALUE;
                res.g = lbr_pkg::PAD_VALUE;
                res.b = lbr_pkg::PAD_VALUE;
                res.pad = 1'b1;
                n_pad++;
            end else begin
                p00 = frame[int'(y0 * STORE_W + x0)];
                p01 = frame[int'(y0 * STORE_W + x1)];
                p10 = frame[int'(y1 * STORE_W + x0)];
                p11 = frame[int'(y1 * STORE_W + x1)];
                for (int c = 0; c < lbr_pkg::CHANNELS; c++) begin
                    sh_bits = 16 - 8 * c;
                    a = (p00 >> sh_bits) & 8'hFF;
                    b = (p01 >> sh_bits) & 8'hFF;
                    d = (p10 >> sh_bits) & 8'hFF;
                    e = (p11 >> sh_bits) & 8'hFF;
                    acc = a * (256 - fx) * (256 - fy) + b * fx * (256 - fy)
                        + d * (256 - fx) * fy + e * fx * fy;
                    case (c)
                        0: res.r = lbr_pkg::OUT_W'(acc >> 8);
                        1: res.g = lbr_pkg::OUT_W'(acc >> 8);
                        default: res.b = lbr_pkg::OUT_W'(acc >> 8);
                    endcase
                end
            end
            pending_q.push_back(res);
        endfunction

        function void check_pixel(t_result_word got);
            t_result_word exp_w;
            n_checked++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: pixel word with none pending: %p", got);
                return;
            end
            exp_w = pending_q.pop_front();
            if (got !== exp_w) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: pixel %0d: exp r=%0d g=%0d b=%0d pad=%0b rerr=%0b, ",
                              "got r=%0d g=%0d b=%0d pad=%0b rerr=%0b"},
                             n_checked, exp_w.r, exp_w.g, exp_w.b, exp_w.pad, exp_w.rerr,
                             got.r, got.g, got.b, got.pad, got.rerr);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [lbr_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [lbr_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;

    lbr_in_if  in_ch();
    lbr_out_if out_ch();

    letterbox_bilinear_resize dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_pixel_scoreboard sb = new();

    bit sender_lazy;     // random gaps between words on the input side
    bit sink_lazy;       // random stalls on the output side
    bit long_hold;       // one long output stall, so the pipe backs up
    int n_sent = 0;      // accepted input words

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = lbr_pkg::KIND_LOAD;
        in_ch.coord_x = '0;
        in_ch.coord_y = '0;
        in_ch.red = '0;
        in_ch.green = '0;
        in_ch.blue = '0;
        out_ch.ready = 1'b0;
    end

    // Output monitor: a word moves at a rising edge with valid and ready high.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_pixel({out_ch.out_red, out_ch.out_green, out_ch.out_blue,
                            out_ch.is_padding, out_ch.range_error});
    end

    // Output side: random stalls, plus one long hold counted here.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = sink_lazy ? $urandom_range(0, 7) : 0;
            if (long_hold) begin
                gap = 300;
                long_hold = 1'b0;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Drive one word; returns at the edge that accepts it.
    task automatic send_word(t_pixel_word w);
        int gap;
        @(negedge i_clk);
        gap = sender_lazy ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= w.kind;
        in_ch.coord_x <= w.x;
        in_ch.coord_y <= w.y;
        in_ch.red     <= w.r;
        in_ch.green   <= w.g;
        in_ch.blue    <= w.b;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_word(w);
        n_sent++;
    endtask

    task automatic send_load(int x, int y);
        t_pixel_word w;
        w.kind = lbr_pkg::KIND_LOAD;
        w.x = lbr_pkg::COORD_W'(x);
        w.y = lbr_pkg::COORD_W'(y);
        w.r = lbr_pkg::CHAN_W'($urandom);
        w.g = lbr_pkg::CHAN_W'($urandom);
        w.b = lbr_pkg::CHAN_W'($urandom);
        send_word(w);
    endtask

    // A request; any neighbor that was never loaded gets a load first.
    task automatic send_request(int x, int y);
        t_pixel_word w;
        longint unsigned x0, x1, y0, y1, fx, fy;
        if (x < sb.dst_w && y < sb.dst_h && sb.sample_at(x, y, x0, x1, y0, y1, fx, fy)) begin
            if (!sb.is_written(x0, y0)) send_load(int'(x0), int'(y0));
            if (!sb.is_written(x1, y0)) send_load(int'(x1), int'(y0));
            if (!sb.is_written(x0, y1)) send_load(int'(x0), int'(y1));
            if (!sb.is_written(x1, y1)) send_load(int'(x1), int'(y1));
        end
        w = '0;
        w.kind = lbr_pkg::KIND_REQ;
        w.x = lbr_pkg::COORD_W'(x);
        w.y = lbr_pkg::COORD_W'(y);
        w.r = lbr_pkg::CHAN_W'($urandom);
        w.g = lbr_pkg::CHAN_W'($urandom);
        w.b = lbr_pkg::CHAN_W'($urandom);
        send_word(w);
    endtask

    // Quiesce, then write all four registers.
    task automatic set_geometry(int sw, int sh, int dw, int dh);
        int vals[4];
        logic [lbr_pkg::CFG_IDX_W-1:0] idx[4];
        vals = '{sw, sh, dw, dh};
        idx = '{lbr_pkg::CFG_SRC_W, lbr_pkg::CFG_SRC_H, lbr_pkg::CFG_DST_W, lbr_pkg::CFG_DST_H};
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[i];
            i_cfg_data <= lbr_pkg::CFG_DAT_W'(vals[i]);
            sb.set_reg(idx[i], lbr_pkg::CFG_DAT_W'(vals[i]));
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Random mix: mostly in-frame requests, some anywhere, some stray loads.
    task automatic random_items(int n);
        int sel;
        int start;
        start = n_sent;
        while (n_sent - start < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 70 && sb.dst_w > 0 && sb.dst_h > 0)
                send_request($urandom_range(0, sb.dst_w - 1), $urandom_range(0, sb.dst_h - 1));
            else if (sel < 82)
                send_request($urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                send_load($urandom_range(0, 4095), $urandom_range(0, 4095));
        end
    endtask

    initial begin
        int sw, sh, dw, dh;
        sender_lazy = 1'b0;
        sink_lazy = 1'b0;
        long_hold = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default 640x640 square, store corners, stores edges, range errors.
        send_load(0, 0);
        send_load(STORE_W - 1, STORE_H - 1);
        send_load(STORE_W, 5);          // outside the store, dropped
        send_load(4095, 4095);          // outside the store, dropped
        send_request(0, 0);
        send_request(639, 639);         // right/bottom neighbor clamps
        send_request(639, 0);
        send_request(640, 0);           // range error
        send_request(0, 640);
        send_request(4095, 4095);

        // Letterbox with top/bottom gray border.
        set_geometry(640, 480, 640, 640);
        send_request(5, 0);
        send_request(5, 79);
        send_request(5, 80);
        send_request(5, 559);
        send_request(5, 560);
        // Pillarbox, single pixel, and zero/oversized register values.
        set_geometry(200, 400, 416, 416);
        send_request(0, 10);
        send_request(415, 10);
        set_geometry(1, 1, 1, 1);
        send_request(0, 0);
        send_request(1, 0);
        set_geometry(0, 0, 4095, 4095);   // zero source size acts as one
        send_request(4094, 4094);
        set_geometry(4095, 3, 4095, 7);   // width saturates to the store size
        send_request(4094, 3);
        set_geometry(5, 9, 0, 9);         // zero width: all range errors
        send_request(0, 0);

        // Random phases with gaps on both sides; one phase with a long output hold.
        for (int ph = 0; ph < 14; ph++) begin
            case (ph)
                0: begin sw = 1024; sh = 1024; dw = 1;    dh = 4095; end
                1: begin sw = 1;    sh = 1024; dw = 4095; dh = 1;    end
                2: begin sw = 640;  sh = 360;  dw = 640;  dh = 640;  end
                3: begin sw = 2047; sh = 0;    dw = 0;    dh = 0;    end
                4: begin sw = 1024; sh = 1;    dw = 4095; dh = 4095; end
                default: begin
                    sw = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 1024);
                    sh = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 1024);
                    dw = $urandom_range(1, 700);
                    dh = $urandom_range(1, 700);
                    if (ph == 13) begin dw = $urandom_range(1, 4095); dh = 4095; end
                end
            endcase
            set_geometry(sw, sh, dw, dh);
            sender_lazy = (ph % 3) != 0;
            sink_lazy = (ph % 4) != 1;
            if (ph == 2) begin
                sender_lazy = 1'b0;
                long_hold = 1'b1;
            end
            random_items(PHASE_WORDS);
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d border, %0d range errors) and %0d loads, 21 settings.",
                 sb.n_req, sb.n_pad, sb.n_rerr, sb.n_load);
        $display("Pixel words checked: %0d, mismatches: %0d", sb.n_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("Timeout with %0d pixel words outstanding", sb.pending_q.size());
        $display("testbench failed");
        $finish;
    end

endmodule
